// File: src/double_ended_queue_assert.svh
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define DEQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/deq_pkg.sv
// Shared constants, types and ring pointer helpers for the deque.
package deq_pkg;

    localparam int CAPACITY = 64;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OCC_W    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP_FWD   = 3'd4,
        OP_DUMP_BWD   = 3'd5,
        OP_SIZE       = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        logic               is_element;
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic               last;
    } t_token;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element;
        logic                      is_element;
        logic [COUNT_W-1:0]        count;
        t_status                   status;
        logic                      last;
    } t_result;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        ptr_prev = (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
    endfunction

endpackage

// File: src/deq_ram.sv
// Entry store: one write port, one read port with registered read data.
module deq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/deq_ctrl.sv
// Deque control: pointers, count, dump sequencer and store access.
module deq_ctrl import deq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_room,
    output logic                o_tok_valid,
    output t_token              o_tok,
    output logic                o_we,
    output logic [PTR_W-1:0]    o_waddr,
    output logic [VALUE_W-1:0]  o_wdata,
    output logic                o_re,
    output logic [PTR_W-1:0]    o_raddr
);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [PTR_W-1:0]   r_back, n_back;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_bwd, n_bwd;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_is_dump;
    logic               w_dump_bwd;
    logic [PTR_W-1:0]   w_start;
    logic [PTR_W-1:0]   w_start_step;
    logic [PTR_W-1:0]   w_rd_step;

    assign o_in_stall   = (r_state != S_IDLE) || !i_room;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_full       = (r_count == COUNT_W'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_dump_bwd   = (i_op == OP_DUMP_BWD);
    assign w_is_dump    = (i_op == OP_DUMP_FWD) || w_dump_bwd;
    assign w_start      = w_dump_bwd ? ptr_prev(r_back) : r_front;
    assign w_start_step = w_dump_bwd ? ptr_prev(w_start) : ptr_next(w_start);
    assign w_rd_step    = r_bwd ? ptr_prev(r_rd_ptr) : ptr_next(r_rd_ptr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_is_dump && (r_count > COUNT_W'(1))) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (i_room && (r_left == COUNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_bwd       = r_bwd;
        o_we        = 1'b0;
        o_waddr     = r_back;
        o_wdata     = i_value;
        o_re        = 1'b0;
        o_raddr     = r_rd_ptr;
        o_tok_valid = 1'b0;
        o_tok       = '{is_element: 1'b0, count: r_count, status: ST_OK, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_tok_valid = 1'b1;
                    case (i_op)
                        OP_PUSH_FRONT: begin
                            if (w_full) begin
                                o_tok.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = ptr_prev(r_front);
                                n_front = ptr_prev(r_front);
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (w_full) begin
                                o_tok.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_back;
                                n_back  = ptr_next(r_back);
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (w_empty) begin
                                o_tok.status = ST_EMPTY;
                            end else begin
                                n_front = ptr_next(r_front);
                                n_count = r_count - COUNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (w_empty) begin
                                o_tok.status = ST_EMPTY;
                            end else begin
                                n_back  = ptr_prev(r_back);
                                n_count = r_count - COUNT_W'(1);
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_BWD: begin
                            if (!w_empty) begin
                                o_re             = 1'b1;
                                o_raddr          = w_start;
                                o_tok.is_element = 1'b1;
                                o_tok.last       = (r_count == COUNT_W'(1));
                                n_rd_ptr         = w_start_step;
                                n_left           = r_count - COUNT_W'(1);
                                n_bwd            = w_dump_bwd;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP: begin
                if (i_room) begin
                    o_tok_valid      = 1'b1;
                    o_re             = 1'b1;
                    o_raddr          = r_rd_ptr;
                    o_tok.is_element = 1'b1;
                    o_tok.last       = (r_left == COUNT_W'(1));
                    n_rd_ptr         = w_rd_step;
                    n_left           = r_left - COUNT_W'(1);
                end
            end
            default: ;
        endcase
        o_tok.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_left   <= n_left;
        r_bwd    <= n_bwd;
    end

endmodule

// File: src/deq_oq.sv
// Result stage: joins store read data with its token and queues finished words.
module deq_oq import deq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tok_valid,
    input  t_token             i_tok,
    input  logic [VALUE_W-1:0] i_rdata,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_result
);

    logic               r_b_valid;
    t_token             r_b_tok;
    t_result            r_q [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wr, n_wr;
    logic [OQ_AW-1:0]   r_rd, n_rd;
    logic [OCC_W-1:0]   r_occ, n_occ;

    logic               w_push;
    logic               w_pop;
    t_result            w_entry;

    assign w_push      = r_b_valid;
    assign w_pop       = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_occ != '0);
    assign o_result    = r_q[r_rd];
    assign o_room      = ((OCC_W + 1)'(r_occ) + (OCC_W + 1)'(r_b_valid))
                         < (OCC_W + 1)'(OQ_DEPTH);

    always_comb begin
        w_entry.element    = r_b_tok.is_element ? i_rdata : '0;
        w_entry.is_element = r_b_tok.is_element;
        w_entry.count      = r_b_tok.count;
        w_entry.status     = r_b_tok.status;
        w_entry.last       = r_b_tok.last;
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_occ = r_occ;
        if (w_push) begin
            n_wr = (r_wr == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_wr + OQ_AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_rd + OQ_AW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_occ = r_occ + OCC_W'(1);
            2'b01:   n_occ = r_occ - OCC_W'(1);
            default: n_occ = r_occ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_occ     <= '0;
        end else begin
            r_b_valid <= i_tok_valid;
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_occ     <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_tok <= i_tok;
        if (w_push) begin
            r_q[r_wr] <= w_entry;
        end
    end

endmodule

// File: src/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Each word's token and store read are registered, then queued in the result queue and offered.
// Throughput: push, pop, size and empty-store dumps take one input word per cycle with result room.
// Dumping N entries gives N words at one read per cycle with result room; input stalls to the last.
// Reset (synchronous, active low) empties the queue and the result stage; store contents are kept.
module double_ended_queue import deq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_element,
    output logic                      o_is_element,
    output logic [COUNT_W-1:0]        o_count,
    output logic [STATUS_W-1:0]       o_status,
    output logic                      o_last
);

    logic               w_room;
    logic               w_tok_valid;
    t_token             w_tok;
    logic               w_we;
    logic [PTR_W-1:0]   w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic               w_re;
    logic [PTR_W-1:0]   w_raddr;
    logic [VALUE_W-1:0] w_rdata;
    t_result            w_result;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_room      (w_room),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr)
    );

    deq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    deq_oq u_oq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .i_rdata     (w_rdata),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_element    = w_result.element;
    assign o_is_element = w_result.is_element;
    assign o_count      = w_result.count;
    assign o_status     = w_result.status;
    assign o_last       = w_result.last;

endmodule

// File: src/deq_chk.sv
// Port-level checker for the deque, bound to the top level.
`include "double_ended_queue_assert.svh"

module deq_chk import deq_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [VALUE_W-1:0] o_element,
    input logic                      o_is_element,
    input logic [COUNT_W-1:0]        o_count,
    input logic [STATUS_W-1:0]       o_status,
    input logic                      o_last
);

    logic                                 w_held;
    logic                                 w_plain;
    logic                                 w_flagged;
    logic [VALUE_W+COUNT_W+STATUS_W+1:0]  w_word;

    assign w_held    = o_out_valid && i_out_stall;
    assign w_plain   = o_out_valid && !o_is_element;
    assign w_flagged = o_out_valid && (o_status != ST_OK);
    assign w_word    = {o_element, o_is_element, o_count, o_status, o_last};

    `DEQ_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `DEQ_ASSERT(a_hold_word, w_held |=> o_out_valid && $stable(w_word), "stalled word changed")
    `DEQ_ASSERT(a_zero_element, w_plain |-> o_element == '0, "element set without dump")
    `DEQ_ASSERT(a_flag_single, w_flagged |-> o_last && !o_is_element, "flagged word not single")
    `DEQ_ASSERT(a_count_range, o_out_valid |-> o_count <= COUNT_W'(CAPACITY), "count too large")

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);
